@@ rtl/tsc_mag_pkg.sv @@
// Shared types and constants for the TSC mass assignment grid.
// No dependencies; imported by the interfaces, the axis weight unit and the core.
package tsc_mag_pkg;

  typedef enum logic [1:0] {
    KIND_DEPOSIT = 2'd0,
    KIND_READ    = 2'd1,
    KIND_CLEAR   = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WEIGHT,
    ST_ISSUE,
    ST_DRAIN,
    ST_READ,
    ST_DONE
  } state_t;

  typedef logic [15:0] weight_t;   // Q0.16 TSC weight
  typedef logic [15:0] pos_t;      // Q0.16 box fraction
  typedef logic [15:0] mass_t;     // Q8.8 mass
  typedef logic [14:0] cell_idx_t;
  typedef logic [31:0] density_t;  // Q16.16 cell value

  // Weights for node-1, node, node+1 along one axis.
  typedef struct packed {
    weight_t lo;
    weight_t mid;
    weight_t hi;
  } axis_w_t;

  localparam logic [31:0] MID_BASE = 32'hC000_0000;  // 0.75 in Q0.32
  localparam logic [16:0] ONE_Q16  = 17'h1_0000;
  localparam logic [15:0] HALF_Q16 = 16'h8000;
  localparam int unsigned AMT_W    = 24;             // width of (w*w*w*m) >> 40
  localparam int unsigned AMT_LSB  = 40;

  function automatic weight_t pick_weight(axis_w_t w, logic [1:0] sel);
    weight_t r;
    case (sel)
      2'd0:    r = w.lo;
      2'd1:    r = w.mid;
      default: r = w.hi;
    endcase
    return r;
  endfunction

endpackage

@@ rtl/tsc_mag_if.sv @@
// Valid/ready channels for the TSC grid: request items in, result items out.
// Depends on tsc_mag_pkg for the payload types.
interface tsc_mag_in_if;
  import tsc_mag_pkg::*;
  logic      valid;
  logic      ready;
  logic [1:0] kind;
  pos_t      pos_x;
  pos_t      pos_y;
  pos_t      pos_z;
  mass_t     mass;
  cell_idx_t cell_index;

  modport source (output valid, kind, pos_x, pos_y, pos_z, mass, cell_index, input ready);
  modport sink   (input valid, kind, pos_x, pos_y, pos_z, mass, cell_index, output ready);
endinterface

interface tsc_mag_out_if;
  import tsc_mag_pkg::*;
  logic     valid;
  logic     ready;
  density_t cell_value;
  logic     saturated;

  modport source (output valid, cell_value, saturated, input ready);
  modport sink   (input valid, cell_value, saturated, output ready);
endinterface

@@ rtl/tsc_mag_axis.sv @@
// Per-axis TSC node and weight unit: nearest node, its neighbours and three Q0.16 weights.
// Depends on tsc_mag_pkg; outputs are registered when en is high.
module tsc_mag_axis #(
  parameter int unsigned GRID_SIZE = 32
) (
  input  logic                         clk,
  input  logic                         en,
  input  tsc_mag_pkg::pos_t            pos,
  output logic [$clog2(GRID_SIZE)-1:0] node_lo,
  output logic [$clog2(GRID_SIZE)-1:0] node_mid,
  output logic [$clog2(GRID_SIZE)-1:0] node_hi,
  output tsc_mag_pkg::axis_w_t         w
);
  import tsc_mag_pkg::*;

  localparam int unsigned L = $clog2(GRID_SIZE);

  logic [16+L:0] r;
  logic [L-1:0]  c;
  logic [15:0]   a;
  logic [16:0]   b;
  logic [15:0]   d;
  logic [31:0]   aa;
  logic [33:0]   bb;
  logic [31:0]   dd;
  logic [31:0]   mid_full;

  // Scale to grid units and round to the nearest node.
  assign r  = {1'b0, pos, {L{1'b0}}} + (17 + L)'(HALF_Q16);
  assign c  = r[16 +: L];
  assign a  = r[15:0];
  assign b  = ONE_Q16 - {1'b0, a};
  assign d  = (a >= HALF_Q16) ? (a - HALF_Q16) : (HALF_Q16 - a);
  assign aa = 32'(a) * 32'(a);
  assign bb = 34'(b) * 34'(b);
  assign dd = 32'(d) * 32'(d);
  assign mid_full = MID_BASE - dd;

  always_ff @(posedge clk) begin
    if (en) begin
      node_lo  <= c - L'(1);
      node_mid <= c;
      node_hi  <= c + L'(1);
      w.lo     <= bb[32:17];
      w.mid    <= mid_full[31:16];
      w.hi     <= {1'b0, aa[31:17]};
    end
  end

endmodule

@@ rtl/tsc_mass_assignment_grid_core.sv @@
// Top level of the TSC mass assignment grid: density memory, cell update pipeline, control.
// Depends on tsc_mag_pkg, tsc_mag_in_if / tsc_mag_out_if and tsc_mag_axis.
//
// Usage
//   din  (sink):   request items. kind 0 deposits a particle with TSC weights into the
//                  27 surrounding cells, kind 1 reads one cell, kind 2 clears grid and flag.
//   dout (source): one result item per request: cell_value (read data, else zero) and
//                  the sticky saturation flag as it stands after the item.
//   Items are handled one at a time. A deposit first registers the weights, then issues
//   one cell read-modify-write per cycle for the 27 cells through the grid memory's read
//   and write ports, then drains the update pipeline and posts the result; the next item
//   is taken in the idle state after that. A read fetches one cell and posts the result.
//   A clear writes one memory word per cycle until all GRID_SIZE^3 cells are zero.
//   After reset the block sweeps the memory to zero with din.ready low, then becomes ready.
//   The result sits in an output register, so the next item is accepted while it waits.
//   If dout stalls, the following item is held just before its result is posted and
//   din.ready stays low until the register frees.
module tsc_mass_assignment_grid_core #(
  parameter int unsigned GRID_SIZE = 32
) (
  input  logic          clk,
  input  logic          rst,
  tsc_mag_in_if.sink    din,
  tsc_mag_out_if.source dout
);
  import tsc_mag_pkg::*;

  localparam int unsigned L     = $clog2(GRID_SIZE);
  localparam int unsigned AW    = 3 * L;
  localparam int unsigned CELLS = GRID_SIZE * GRID_SIZE * GRID_SIZE;

  state_t state, state_next;

  // Latched request
  logic [1:0] kind;
  pos_t       pos_x, pos_y, pos_z;
  mass_t      mass;
  cell_idx_t  cell_index;

  // Control
  logic          accept, issue, clr_we, rd_re, load_out, last_cell, clr_last;
  logic          init_pass;
  logic [1:0]    ci, cj, ck;
  logic [AW-1:0] clr_addr;

  // Axis outputs
  logic [L-1:0] nx_lo, nx_mid, nx_hi, ny_lo, ny_mid, ny_hi, nz_lo, nz_mid, nz_hi;
  axis_w_t      wx, wy, wz;
  logic [L-1:0] sel_x, sel_y, sel_z;

  // Update pipeline
  logic          s1_valid, s2_valid;
  logic [AW-1:0] s1_addr, s2_addr;
  logic [31:0]   s1_wxy, s1_wzm;
  logic [63:0]   prod;
  logic [AMT_W-1:0] s2_amt;
  logic [32:0]   sum;
  density_t      upd_value;
  logic          upd_sat;

  // Memory
  density_t      grid_mem [CELLS];
  density_t      rdata;
  logic          mem_we, mem_re;
  logic [AW-1:0] mem_waddr, mem_raddr, rd_addr;
  density_t      mem_wdata;
  logic [31:0]   idx_ext;
  logic          rd_in_range;

  logic     sat;
  logic     out_valid, out_sat;
  density_t out_value;

  tsc_mag_axis #(.GRID_SIZE(GRID_SIZE)) u_axis_x (
    .clk(clk), .en(state == ST_WEIGHT), .pos(pos_x),
    .node_lo(nx_lo), .node_mid(nx_mid), .node_hi(nx_hi), .w(wx)
  );
  tsc_mag_axis #(.GRID_SIZE(GRID_SIZE)) u_axis_y (
    .clk(clk), .en(state == ST_WEIGHT), .pos(pos_y),
    .node_lo(ny_lo), .node_mid(ny_mid), .node_hi(ny_hi), .w(wy)
  );
  tsc_mag_axis #(.GRID_SIZE(GRID_SIZE)) u_axis_z (
    .clk(clk), .en(state == ST_WEIGHT), .pos(pos_z),
    .node_lo(nz_lo), .node_mid(nz_mid), .node_hi(nz_hi), .w(wz)
  );

  assign accept    = din.valid && din.ready;
  assign last_cell = (ci == 2'd2) && (cj == 2'd2) && (ck == 2'd2);
  assign clr_last  = &clr_addr;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR:  if (clr_last) state_next = init_pass ? ST_IDLE : ST_DONE;
      ST_IDLE: begin
        if (accept) begin
          if (din.kind == KIND_DEPOSIT)    state_next = ST_WEIGHT;
          else if (din.kind == KIND_READ)  state_next = ST_READ;
          else if (din.kind == KIND_CLEAR) state_next = ST_CLEAR;
          else                             state_next = ST_DONE;
        end
      end
      ST_WEIGHT: state_next = ST_ISSUE;
      ST_ISSUE:  if (last_cell) state_next = ST_DRAIN;
      ST_DRAIN:  if (!s1_valid && !s2_valid) state_next = ST_DONE;
      ST_READ:   state_next = ST_DONE;
      ST_DONE:   if (load_out) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // State outputs
  always_comb begin
    din.ready = 1'b0;
    issue     = 1'b0;
    clr_we    = 1'b0;
    rd_re     = 1'b0;
    load_out  = 1'b0;
    unique case (state)
      ST_CLEAR:  clr_we = 1'b1;
      ST_IDLE:   din.ready = 1'b1;
      ST_ISSUE:  issue = 1'b1;
      ST_READ:   rd_re = 1'b1;
      ST_DONE:   load_out = !out_valid || dout.ready;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLEAR;
      init_pass <= 1'b1;
      clr_addr  <= '0;
      ci        <= '0;
      cj        <= '0;
      ck        <= '0;
    end else begin
      state <= state_next;
      if (clr_we) begin
        clr_addr <= clr_addr + AW'(1);
        if (clr_last) init_pass <= 1'b0;
      end
      // Walk i fastest, then j, then k
      if (issue) begin
        if (ci == 2'd2) begin
          ci <= '0;
          if (cj == 2'd2) begin
            cj <= '0;
            ck <= (ck == 2'd2) ? 2'd0 : ck + 2'd1;
          end else begin
            cj <= cj + 2'd1;
          end
        end else begin
          ci <= ci + 2'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind       <= din.kind;
      pos_x      <= din.pos_x;
      pos_y      <= din.pos_y;
      pos_z      <= din.pos_z;
      mass       <= din.mass;
      cell_index <= din.cell_index;
    end
  end

  // Stage 1: pick the cell and form the two partial products
  always_comb begin
    case (ci)
      2'd0:    sel_x = nx_lo;
      2'd1:    sel_x = nx_mid;
      default: sel_x = nx_hi;
    endcase
    case (cj)
      2'd0:    sel_y = ny_lo;
      2'd1:    sel_y = ny_mid;
      default: sel_y = ny_hi;
    endcase
    case (ck)
      2'd0:    sel_z = nz_lo;
      2'd1:    sel_z = nz_mid;
      default: sel_z = nz_hi;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_addr <= {sel_x, sel_y, sel_z};
    s1_wxy  <= 32'(pick_weight(wx, ci)) * 32'(pick_weight(wy, cj));
    s1_wzm  <= 32'(pick_weight(wz, ck)) * 32'(mass);
    // Stage 2: full product, keep the Q8.16 amount
    s2_addr <= s1_addr;
    s2_amt  <= prod[AMT_LSB +: AMT_W];
  end

  assign prod = 64'(s1_wxy) * 64'(s1_wzm);

  // Stage 3: saturating add onto the stored cell
  assign sum       = {1'b0, rdata} + 33'(s2_amt);
  assign upd_sat   = sum[32];
  assign upd_value = upd_sat ? '1 : sum[31:0];

  // Memory port control
  assign idx_ext     = 32'(cell_index);
  assign rd_addr     = idx_ext[AW-1:0];
  assign rd_in_range = idx_ext < 32'(CELLS);

  always_comb begin
    mem_we    = clr_we || s2_valid;
    mem_waddr = clr_we ? clr_addr : s2_addr;
    mem_wdata = clr_we ? '0 : upd_value;
    mem_re    = rd_re || s1_valid;
    mem_raddr = rd_re ? rd_addr : s1_addr;
  end

  always_ff @(posedge clk) begin
    if (mem_we) grid_mem[mem_waddr] <= mem_wdata;
    if (mem_re) rdata <= grid_mem[mem_raddr];
  end

  // Sticky flag
  always_ff @(posedge clk) begin
    if (rst) begin
      sat <= 1'b0;
    end else if (accept && din.kind == KIND_CLEAR) begin
      sat <= 1'b0;
    end else if (s2_valid && upd_sat) begin
      sat <= 1'b1;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (dout.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_value <= (kind == KIND_READ && rd_in_range) ? rdata : '0;
      out_sat   <= sat;
    end
  end

  assign dout.valid      = out_valid;
  assign dout.cell_value = out_value;
  assign dout.saturated  = out_sat;

endmodule

@@ rtl/tsc_mag_checker.sv @@
// Port-level checks for the TSC grid core, attached by the bind at the end of this file.
// Depends only on the core's ports.
module tsc_mag_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [31:0] cell_value,
  input logic        saturated
);

  logic [1:0] pend;

  // Count items accepted whose result has not yet been taken
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + 2'(in_valid && in_ready) - 2'(out_valid && out_ready);
    end
  end

  a_clear_after_reset: assert property (@(posedge clk) rst |=> !in_ready)
    else $error("input ready during the clearing pass after reset");

  a_two_in_flight: assert property (@(posedge clk) disable iff (rst)
    (pend == 2'd2) |-> !in_ready)
    else $error("third item accepted while two are pending");

  a_result_has_item: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pend != 2'd0))
    else $error("result presented with no item pending");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(cell_value) && $stable(saturated)))
    else $error("stalled result changed");

endmodule

bind tsc_mass_assignment_grid_core tsc_mag_checker u_tsc_mag_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (din.valid),
  .in_ready  (din.ready),
  .out_valid (dout.valid),
  .out_ready (dout.ready),
  .cell_value(dout.cell_value),
  .saturated (dout.saturated)
);

@@ test/tsc_mass_assignment_grid_tb.sv @@
// Self-checking testbench for tsc_mass_assignment_grid_core: TSC deposits, cell reads and clears
// on valid/ready channels, checked against a cell-accurate predictor of the density grid.
// Depends on tsc_mag_pkg, tsc_mag_in_if / tsc_mag_out_if and the core RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import tsc_mag_pkg::*;

  localparam int unsigned GRID_N      = 32;
  localparam int unsigned GRID_CELLS  = GRID_N * GRID_N * GRID_N;
  localparam logic [1:0]  KIND_UNUSED = 2'd3;
  localparam int unsigned IDLE_PCT    = 12;
  localparam int unsigned STALL_LIMIT = 100000;  // must outlast a clear or the reset sweep
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned SAT_DEPOSITS = 620;    // 607 full-mass centred deposits saturate
  localparam int unsigned RANDOM_ITEMS = 1250;

  typedef struct packed {
    int unsigned node;
    bit [63:0]   lo;
    bit [63:0]   mid;
    bit [63:0]   hi;
  } axis_t;

  typedef struct packed {
    density_t cell_value;
    logic     saturated;
  } cell_result_t;

  logic clk = 1'b0;
  logic rst;

  tsc_mag_in_if  din ();
  tsc_mag_out_if dout ();

  tsc_mass_assignment_grid_core #(.GRID_SIZE(GRID_N)) dut (
    .clk  (clk),
    .rst  (rst),
    .din  (din),
    .dout (dout)
  );

  always #10 clk = ~clk;

  bit [31:0]      grid_model [0:GRID_CELLS-1];
  bit             sat_model;
  cell_result_t   grid_answers [$];
  int unsigned    last_node [3];
  pos_t           hot_pos [3];
  bit             calm = 1'b0;
  int             hold_left = 0;
  int             fail_count = 0;
  int             stall_cycles = 0;
  int             n_deposit = 0, n_read = 0, n_clear = 0, n_unused = 0, n_results = 0;
  bit             saw_saturation = 1'b0;

  // Per-axis node and Q0.16 weights for node-1, node and node+1.
  function automatic axis_t axis_tsc(pos_t p);
    axis_t     s;
    bit [31:0] r;
    bit [63:0] a, b, d;
    r      = {16'd0, p} * GRID_N + 32'd32768;
    s.node = (r >> 16) & (GRID_N - 1);
    a      = {48'd0, r[15:0]};
    b      = 64'd65536 - a;
    d      = (a >= 64'd32768) ? a - 64'd32768 : 64'd32768 - a;
    s.lo   = (b * b) >> 17;
    s.mid  = ((64'd3 << 30) - d * d) >> 16;
    s.hi   = (a * a) >> 17;
    return s;
  endfunction

  function automatic bit [63:0] axis_weight(axis_t s, int i);
    return (i == 0) ? s.lo : (i == 1) ? s.mid : s.hi;
  endfunction

  function automatic int unsigned axis_node(axis_t s, int i);
    return (i == 0) ? (s.node + GRID_N - 1) % GRID_N :
           (i == 1) ? s.node : (s.node + 1) % GRID_N;
  endfunction

  // Apply one item to the grid copy and return the result it must produce.
  function automatic cell_result_t grid_step(logic [1:0] k, pos_t px, pos_t py, pos_t pz,
                                             mass_t m, cell_idx_t ci);
    cell_result_t res;
    axis_t        ax, ay, az;
    bit [63:0]    prod, total;
    int unsigned  idx;
    res.cell_value = '0;
    case (k)
      KIND_DEPOSIT: begin
        ax = axis_tsc(px);
        ay = axis_tsc(py);
        az = axis_tsc(pz);
        for (int l = 0; l < 3; l++)
          for (int j = 0; j < 3; j++)
            for (int i = 0; i < 3; i++) begin
              prod  = axis_weight(ax, i) * axis_weight(ay, j) * axis_weight(az, l)
                      * {48'd0, m};
              idx   = (axis_node(ax, i) * GRID_N + axis_node(ay, j)) * GRID_N
                      + axis_node(az, l);
              total = {32'd0, grid_model[idx]} + (prod >> 40);
              if (total > 64'hFFFF_FFFF) begin
                total     = 64'hFFFF_FFFF;
                sat_model = 1'b1;
              end
              grid_model[idx] = total[31:0];
            end
      end
      KIND_READ: begin
        if (ci < GRID_CELLS) res.cell_value = grid_model[ci];
      end
      KIND_CLEAR: begin
        foreach (grid_model[i]) grid_model[i] = '0;
        sat_model = 1'b0;
      end
      default: ;
    endcase
    res.saturated = sat_model;
    return res;
  endfunction

  task automatic report_mismatch(string what);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH: %s", what);
  endtask

  // Offer one item, wait for acceptance, record its prediction.
  task automatic send_item(logic [1:0] k, pos_t px, pos_t py, pos_t pz, mass_t m,
                           cell_idx_t ci);
    int gap;
    gap = 0;
    if (!calm) while ($urandom_range(99) < IDLE_PCT) gap++;
    if (gap > 0) begin
      din.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    din.valid      <= 1'b1;
    din.kind       <= k;
    din.pos_x      <= px;
    din.pos_y      <= py;
    din.pos_z      <= pz;
    din.mass       <= m;
    din.cell_index <= ci;
    do @(posedge clk); while (!din.ready);
    grid_answers.push_back(grid_step(k, px, py, pz, m, ci));
    case (k)
      KIND_DEPOSIT: n_deposit++;
      KIND_READ:    n_read++;
      KIND_CLEAR:   n_clear++;
      default:      n_unused++;
    endcase
  endtask

  task automatic send_deposit(pos_t px, pos_t py, pos_t pz, mass_t m);
    axis_t s;
    s = axis_tsc(px);
    last_node[0] = s.node;
    s = axis_tsc(py);
    last_node[1] = s.node;
    s = axis_tsc(pz);
    last_node[2] = s.node;
    send_item(KIND_DEPOSIT, px, py, pz, m, cell_idx_t'($urandom));
  endtask

  task automatic send_read(cell_idx_t ci);
    send_item(KIND_READ, pos_t'($urandom), pos_t'($urandom), pos_t'($urandom),
              mass_t'($urandom), ci);
  endtask

  task automatic send_clear();
    send_item(KIND_CLEAR, pos_t'($urandom), pos_t'($urandom), pos_t'($urandom),
              mass_t'($urandom), cell_idx_t'($urandom));
  endtask

  task automatic send_unused();
    send_item(KIND_UNUSED, pos_t'($urandom), pos_t'($urandom), pos_t'($urandom),
              mass_t'($urandom), cell_idx_t'($urandom));
  endtask

  // Hold off new items until every result has come back.
  task automatic wait_drained();
    din.valid <= 1'b0;
    do @(posedge clk); while (grid_answers.size() != 0);
  endtask

  // One of the 27 cells around the latest deposit.
  function automatic cell_idx_t cell_near();
    int unsigned x, y, z;
    x = (last_node[0] + GRID_N - 1 + $urandom_range(2)) % GRID_N;
    y = (last_node[1] + GRID_N - 1 + $urandom_range(2)) % GRID_N;
    z = (last_node[2] + GRID_N - 1 + $urandom_range(2)) % GRID_N;
    return cell_idx_t'((x * GRID_N + y) * GRID_N + z);
  endfunction

  function automatic pos_t pick_pos(int axis);
    case ($urandom_range(9))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return pos_t'(($urandom_range(GRID_N - 1) << 11) + 1024);  // between two nodes
      3:       return pos_t'($urandom_range(GRID_N - 1) << 11);           // on a node
      4, 5, 6: return pos_t'(hot_pos[axis] + $urandom_range(4095) - 2048);
      default: return pos_t'($urandom);
    endcase
  endfunction

  function automatic mass_t pick_mass();
    case ($urandom_range(9))
      0:       return 16'hFFFF;
      1:       return mass_t'($urandom_range(3));
      default: return mass_t'($urandom);
    endcase
  endfunction

  // Receiver: random stalls, calm stretches and requested long hold-offs.
  always @(posedge clk) begin
    if (hold_left > 0) begin
      hold_left--;
      dout.ready <= 1'b0;
    end else begin
      dout.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : check_results
    cell_result_t want;
    if (!rst && dout.valid && dout.ready) begin
      n_results++;
      if (dout.saturated) saw_saturation = 1'b1;
      if (grid_answers.size() == 0) begin
        report_mismatch($sformatf("result %0d with nothing pending: cell_value %h saturated %b",
                                  n_results, dout.cell_value, dout.saturated));
      end else begin
        want = grid_answers.pop_front();
        if (dout.cell_value !== want.cell_value || dout.saturated !== want.saturated)
          report_mismatch($sformatf(
            "result %0d: cell_value exp %h got %h, saturated exp %b got %b", n_results,
            want.cell_value, dout.cell_value, want.saturated, dout.saturated));
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (din.valid && din.ready) || (dout.valid && dout.ready)) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Watchdog: no item moved for %0d cycles", STALL_LIMIT);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Field extremes, wrap at both grid faces, node and boundary offsets, unused kind.
  task automatic test_directed();
    send_read(15'd0);
    send_read(15'h7FFF);
    send_item(KIND_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 15'h7FFF);
    send_deposit(16'h0000, 16'h0000, 16'h0000, 16'd256);
    send_read(15'd0);
    send_read(15'h7FFF);
    send_read(15'd1);
    send_read(15'd1057);
    send_read(15'd31744);
    send_deposit(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_deposit(16'd1024, 16'd2048, 16'd64512, 16'd1);
    send_deposit(16'h5555, 16'hAAAA, 16'h8000, 16'hAAAA);
    send_deposit(pos_t'($urandom), pos_t'($urandom), pos_t'($urandom), 16'h0000);
    send_read(cell_near());
    send_read(15'd0);
    send_clear();
    send_read(15'd0);
    send_read(15'h7FFF);
    wait_drained();
  endtask

  // Pile full-mass particles onto one node until its cell clips.
  task automatic test_saturation();
    repeat (SAT_DEPOSITS) send_deposit(16'h0000, 16'h0000, 16'h0000, 16'hFFFF);
    send_read(15'd0);
    send_read(15'd1);
    send_unused();
    send_deposit(16'd2048, 16'd2048, 16'd2048, 16'd256);
    send_clear();
    send_read(15'd0);
    wait_drained();
  endtask

  // Stall the result side long enough for the block to back up onto its input.
  task automatic test_backpressure();
    hold_left = 300;
    repeat (6) send_deposit(pick_pos(0), pick_pos(1), pick_pos(2), pick_mass());
    repeat (4) send_read(cell_near());
    wait_drained();
  endtask

  task automatic test_random();
    int done;
    int choice;
    done = 0;
    foreach (hot_pos[a]) hot_pos[a] = pos_t'($urandom);
    while (done < RANDOM_ITEMS) begin
      calm   = (done >= 450 && done < 750);
      choice = $urandom_range(999);
      if ($urandom_range(99) == 0) foreach (hot_pos[a]) hot_pos[a] = pos_t'($urandom);
      if (choice < 3) begin
        send_clear();
        done++;
      end else if (choice < 40) begin
        send_unused();
      end else if (choice < 420) begin
        send_read(($urandom_range(3) != 0) ? cell_near() : cell_idx_t'($urandom));
        done++;
      end else begin
        send_deposit(pick_pos(0), pick_pos(1), pick_pos(2), pick_mass());
        done++;
      end
    end
    calm = 1'b0;
    wait_drained();
  endtask

  initial begin
    rst            <= 1'b1;
    din.valid      <= 1'b0;
    din.kind       <= KIND_DEPOSIT;
    din.pos_x      <= '0;
    din.pos_y      <= '0;
    din.pos_z      <= '0;
    din.mass       <= '0;
    din.cell_index <= '0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_saturation();
    test_backpressure();
    test_random();

    repeat (TAIL_CYCLES) @(posedge clk);
    if (grid_answers.size() != 0)
      report_mismatch($sformatf("%0d results never arrived", grid_answers.size()));

    $display("Run covered %0d deposits, %0d reads, %0d clears and %0d unused-kind items.",
             n_deposit, n_read, n_clear, n_unused);
    $display("%0d results checked, saturation %s, %0d mismatches.", n_results,
             saw_saturation ? "reached" : "not reached", fail_count);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

@@ sim.f @@
rtl/tsc_mag_pkg.sv
rtl/tsc_mag_if.sv
rtl/tsc_mag_axis.sv
rtl/tsc_mass_assignment_grid_core.sv
rtl/tsc_mag_checker.sv
test/tsc_mass_assignment_grid_tb.sv
